[hw/rtl/circular_trace_buffer_defines.svh]
// Assertion helpers for the trace buffer.
`ifndef CIRCULAR_TRACE_BUFFER_DEFINES_SVH
`define CIRCULAR_TRACE_BUFFER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CTB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define CTB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/ctb_pkg.sv]
package ctb_pkg;

	// item kinds
	localparam logic [1:0] KIND_RECORD = 2'd0;
	localparam logic [1:0] KIND_READ   = 2'd1;
	localparam logic [1:0] KIND_CLEAR  = 2'd2;

	localparam int unsigned IDX_W = 16;

	typedef struct packed {
		logic [31:0] stamp;
		logic [15:0] evt_code;
		logic [15:0] evt_value;
	} ctb_entry_t;

	// pointer update commands for one accepted word
	typedef struct packed {
		logic rec;
		logic clr;
	} ctb_cmd_t;

endpackage

[hw/rtl/ctb_ptrs.sv]
module ctb_ptrs #(
	parameter int unsigned CAPACITY = 256,
	parameter int unsigned AW = 8,
	parameter int unsigned CW = 9
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  ctb_pkg::ctb_cmd_t        cmd,
	input  logic [ctb_pkg::IDX_W-1:0] read_index,
	output logic [AW-1:0]            wr_slot,
	output logic [AW-1:0]            rd_slot,
	output logic                     hit,
	output logic [CW-1:0]            held_count
);
	import ctb_pkg::*;

	logic [AW-1:0] head_q;
	logic [CW-1:0] count_q;
	logic          full;
	logic [AW-1:0] start;
	logic [CW:0]   sum;
	logic [CW:0]   sum_wrapped;

	assign full = (count_q == CW'(CAPACITY));
	assign hit  = (read_index < IDX_W'(count_q));

	// oldest entry: head once wrapped, slot 0 before
	assign start = full ? head_q : '0;
	// idx < count <= CAPACITY on a hit, so the sum stays below twice the capacity
	assign sum = (CW+1)'(start) + (CW+1)'(read_index[CW-1:0]);
	assign sum_wrapped = (sum >= (CW+1)'(CAPACITY)) ? sum - (CW+1)'(CAPACITY) : sum;
	assign rd_slot = sum_wrapped[AW-1:0];
	assign wr_slot = head_q;
	assign held_count = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else if (cmd.clr) begin
			head_q  <= '0;
			count_q <= '0;
		end else if (cmd.rec) begin
			head_q <= (head_q == AW'(CAPACITY - 1)) ? '0 : head_q + 1'b1;
			if (!full) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

endmodule

[hw/rtl/ctb_store.sv]
module ctb_store #(
	parameter int unsigned CAPACITY = 256,
	parameter int unsigned AW = 8
) (
	input  logic                clk,
	input  logic                wr_en,
	input  logic [AW-1:0]       wr_addr,
	input  ctb_pkg::ctb_entry_t wr_data,
	input  logic                rd_en,
	input  logic [AW-1:0]       rd_addr,
	output ctb_pkg::ctb_entry_t rd_data
);
	import ctb_pkg::*;

	ctb_entry_t mem [CAPACITY];
	ctb_entry_t rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read register doubles as the result payload; holds while stalled
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

[hw/rtl/circular_trace_buffer.sv]
// Circular trace buffer: keeps the last CAPACITY records (timestamp, event code,
// value) in a wrapping store, one word per cycle on the input channel. A record
// word writes at the head slot when enabled; a clear word empties the buffer
// (entries stay but are no longer held); a read word names an entry by age, 0
// being the oldest, and returns exactly one result word in the next cycle from the
// store's registered read port, with found low and zero payload when the index
// is at or beyond the held count. Record and clear words give no result. Any
// mix of words is taken at one per cycle; the only stall is a read word arriving
// while an earlier result still waits on out_ready, since the store's read
// register is the result register. The store needs no clearing pass after
// reset. The enable register (reset 1) is written over the cfg channel; the user
// must write it only while the block is idle, which the block does not enforce.
`include "circular_trace_buffer_defines.svh"

module circular_trace_buffer #(
	parameter int unsigned CAPACITY = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data,
	// input words
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  kind,
	input  logic [15:0] event_code,
	input  logic [15:0] event_value,
	input  logic [31:0] now_ms,
	input  logic [15:0] read_index,
	// result words
	output logic        out_valid,
	input  logic        out_ready,
	output logic        found,
	output logic [31:0] stamp_out,
	output logic [15:0] event_out,
	output logic [15:0] value_out
);
	import ctb_pkg::*;

	localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int unsigned CW = $clog2(CAPACITY + 1);

	logic          enabled_q;
	logic          out_valid_q;
	logic          found_q;
	logic          in_acc;
	logic          rd_acc;
	ctb_cmd_t      cmd;
	logic [AW-1:0] wr_slot;
	logic [AW-1:0] rd_slot;
	logic          hit;
	logic [CW-1:0] held_count;
	ctb_entry_t    wr_entry;
	ctb_entry_t    rd_entry;

	// config: always ready, single enable bit
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			enabled_q <= cfg_data;
		end
	end

	// only a read needs the result register free
	assign in_ready = !out_valid_q || out_ready || (kind != KIND_READ);
	assign in_acc   = in_valid && in_ready;
	assign rd_acc   = in_acc && (kind == KIND_READ);

	assign cmd.rec = in_acc && (kind == KIND_RECORD) && enabled_q;
	assign cmd.clr = in_acc && (kind == KIND_CLEAR);

	ctb_ptrs #(
		.CAPACITY (CAPACITY),
		.AW       (AW),
		.CW       (CW)
	) u_ptrs (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.read_index (read_index),
		.wr_slot    (wr_slot),
		.rd_slot    (rd_slot),
		.hit        (hit),
		.held_count (held_count)
	);

	assign wr_entry.stamp     = now_ms;
	assign wr_entry.evt_code  = event_code;
	assign wr_entry.evt_value = event_value;

	ctb_store #(
		.CAPACITY (CAPACITY),
		.AW       (AW)
	) u_store (
		.clk     (clk),
		.wr_en   (cmd.rec),
		.wr_addr (wr_slot),
		.wr_data (wr_entry),
		.rd_en   (rd_acc),
		.rd_addr (rd_slot),
		.rd_data (rd_entry)
	);

	// result valid; payload sits in the store's read register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rd_acc) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_acc) begin
			found_q <= hit;
		end
	end

	assign out_valid = out_valid_q;
	assign found     = found_q;
	// a miss reads some slot anyway; mask it to zero
	assign stamp_out = found_q ? rd_entry.stamp     : '0;
	assign event_out = found_q ? rd_entry.evt_code  : '0;
	assign value_out = found_q ? rd_entry.evt_value : '0;

	`CTB_ASSERT_NOW(a_count_bound, clk, arst_n, 1'b1, held_count <= CW'(CAPACITY), "held count beyond capacity")
	`CTB_ASSERT_NEXT(a_read_result, clk, arst_n, rd_acc, out_valid, "read word gave no result")
	`CTB_ASSERT_NEXT(a_clear_empty, clk, arst_n, cmd.clr, held_count == '0, "clear left entries held")
	`CTB_ASSERT_NEXT(a_record_count, clk, arst_n, cmd.rec && (held_count != CW'(CAPACITY)), held_count == $past(held_count) + 1'b1, "record did not grow count")

endmodule
